@@ sv/keypad_password_lock_macros.svh @@
// ----------------------------------------------------------------------------
// Keypad password lock assertion macros
// Shared property wrappers on the aclk / aresetn pair of the lock.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PASSWORD_LOCK_MACROS_SVH
`define KEYPAD_PASSWORD_LOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KPL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/kpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad password lock package
// Command, key and mode codes, register indexes and the controller interface.
// ----------------------------------------------------------------------------
package kpl_pkg;

    // Item command codes.
    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_MENU = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // Key codes with a special meaning.
    localparam logic [7:0] KEY_NONE   = 8'h00;
    localparam logic [7:0] KEY_CHECK  = 8'h31;
    localparam logic [7:0] KEY_CHANGE = 8'h32;
    localparam logic [7:0] KEY_CLEAR  = 8'h43;

    // ASCII '1', first digit of the reset password.
    localparam logic [7:0] DIGIT_BASE = 8'h31;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 8'd1;

    localparam logic [15:0] IDLE_LIMIT_RST = 16'd20;
    localparam logic [3:0]  MAX_ATT_RST    = 4'd3;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;
    localparam logic [3:0]  FAIL_MAX       = 4'hF;

    typedef enum logic [1:0] {
        MODE_CHOOSE = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_CHANGE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_RESOLVE,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic exec;
        logic cmp_step;
        logic resolve;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_cmp;
        logic cmp_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/kpl_datapath.sv @@
// ----------------------------------------------------------------------------
// Keypad password lock datapath
// Item register, lock state, password stores, serial compare and result register.
// ----------------------------------------------------------------------------
module kpl_datapath #(
    parameter int PASS_LEN = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  kpl_pkg::ctrl_cmd_t              ctrl_cmd,
    output kpl_pkg::dp_status_t             dp_status,
    input  logic [1:0]                      s_cmd,
    input  logic [7:0]                      s_key_code,
    input  logic                            cfg_valid,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kpl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_view,
    output logic [1:0]                      m_mode,
    output logic                            m_digit_taken,
    output logic                            m_unlocked,
    output logic                            m_wrong_retry,
    output logic                            m_alarm,
    output logic                            m_pass_changed,
    output logic                            m_timed_out
);

    localparam int POS_W = $clog2(PASS_LEN + 1);
    localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(PASS_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PASS_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PASS_LEN - 1);

    logic [1:0]           item_cmd_reg;
    logic [7:0]           item_key_reg;

    logic [15:0]          idle_limit_reg;
    logic [3:0]           max_att_reg;

    logic                 menu_reg,     menu_next;
    kpl_pkg::mode_t       mode_reg,     mode_next;
    logic [POS_W-1:0]     entry_pos_reg, entry_pos_next;
    logic [POS_W-1:0]     chg_pos_reg,  chg_pos_next;
    logic [3:0]           fail_reg,     fail_next;
    logic [15:0]          idle_reg,     idle_next;
    logic [7:0]           entered_reg [PASS_LEN];
    logic [7:0]           entered_next [PASS_LEN];
    logic [7:0]           stored_reg [PASS_LEN];
    logic [7:0]           stored_next [PASS_LEN];

    logic                 taken_reg,  taken_next;
    logic                 unl_reg,    unl_next;
    logic                 retry_reg,  retry_next;
    logic                 alarm_reg,  alarm_next;
    logic                 chg_reg,    chg_next;
    logic                 tmo_reg,    tmo_next;

    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 mismatch_reg;
    logic                 m_valid_reg;

    logic                 need_cmp;
    logic [15:0]          idle_inc;
    logic [3:0]           fail_inc;

    assign idle_inc = (idle_reg != kpl_pkg::IDLE_MAX) ? idle_reg + 16'd1 : idle_reg;
    assign fail_inc = (fail_reg != kpl_pkg::FAIL_MAX) ? fail_reg + 4'd1 : fail_reg;

    always_comb begin
        menu_next      = menu_reg;
        mode_next      = mode_reg;
        entry_pos_next = entry_pos_reg;
        chg_pos_next   = chg_pos_reg;
        fail_next      = fail_reg;
        idle_next      = idle_reg;
        entered_next   = entered_reg;
        stored_next    = stored_reg;
        taken_next     = taken_reg;
        unl_next       = unl_reg;
        retry_next     = retry_reg;
        alarm_next     = alarm_reg;
        chg_next       = chg_reg;
        tmo_next       = tmo_reg;
        need_cmp       = 1'b0;

        if (ctrl_cmd.exec) begin
            taken_next = 1'b0;
            unl_next   = 1'b0;
            retry_next = 1'b0;
            alarm_next = 1'b0;
            chg_next   = 1'b0;
            tmo_next   = 1'b0;
            case (item_cmd_reg)
                kpl_pkg::CMD_MENU: begin
                    if (!menu_reg) begin
                        idle_next = 16'd0;
                    end
                    menu_next = 1'b1;
                end
                kpl_pkg::CMD_TICK: begin
                    if (menu_reg) begin
                        if (idle_inc >= idle_limit_reg) begin
                            menu_next = 1'b0;
                            idle_next = 16'd0;
                            tmo_next  = 1'b1;
                        end else begin
                            idle_next = idle_inc;
                        end
                    end
                end
                kpl_pkg::CMD_KEY: begin
                    if (menu_reg && item_key_reg != kpl_pkg::KEY_NONE) begin
                        idle_next = 16'd0;
                        if (mode_reg == kpl_pkg::MODE_CHOOSE) begin
                            if (item_key_reg == kpl_pkg::KEY_CHECK) begin
                                mode_next      = kpl_pkg::MODE_CHECK;
                                entry_pos_next = '0;
                            end else if (item_key_reg == kpl_pkg::KEY_CHANGE) begin
                                mode_next    = kpl_pkg::MODE_CHANGE;
                                chg_pos_next = '0;
                            end
                        end else if (item_key_reg == kpl_pkg::KEY_CLEAR) begin
                            entry_pos_next = '0;
                            chg_pos_next   = '0;
                            for (int j = 0; j < PASS_LEN; j++) begin
                                entered_next[j] = 8'd0;
                            end
                            mode_next = kpl_pkg::MODE_CHOOSE;
                        end else if (mode_reg == kpl_pkg::MODE_CHECK) begin
                            if (entry_pos_reg < POS_FULL) begin
                                entered_next[entry_pos_reg[IDX_W-1:0]] = item_key_reg;
                                entry_pos_next = entry_pos_reg + POS_W'(1);
                                taken_next     = 1'b1;
                                // The last digit starts the compare against the store.
                                need_cmp       = (entry_pos_reg == POS_LAST);
                            end
                        end else if (mode_reg == kpl_pkg::MODE_CHANGE) begin
                            if (chg_pos_reg < POS_FULL) begin
                                stored_next[chg_pos_reg[IDX_W-1:0]] = item_key_reg;
                                chg_pos_next = chg_pos_reg + POS_W'(1);
                                taken_next   = 1'b1;
                                chg_next     = (chg_pos_reg == POS_LAST);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (ctrl_cmd.resolve) begin
            if (!mismatch_reg) begin
                unl_next  = 1'b1;
                fail_next = 4'd0;
            end else if (fail_inc >= max_att_reg) begin
                // Entry stays full, so further digits are ignored until a clear.
                alarm_next = 1'b1;
                fail_next  = 4'd0;
            end else begin
                retry_next     = 1'b1;
                fail_next      = fail_inc;
                entry_pos_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg <= kpl_pkg::IDLE_LIMIT_RST;
            max_att_reg    <= kpl_pkg::MAX_ATT_RST;
            menu_reg       <= 1'b0;
            mode_reg       <= kpl_pkg::MODE_CHOOSE;
            entry_pos_reg  <= '0;
            chg_pos_reg    <= '0;
            fail_reg       <= 4'd0;
            idle_reg       <= 16'd0;
            for (int j = 0; j < PASS_LEN; j++) begin
                stored_reg[j]  <= 8'(kpl_pkg::DIGIT_BASE + 8'(j % 9));
                entered_reg[j] <= 8'(kpl_pkg::DIGIT_BASE + 8'((PASS_LEN - 1 - j) % 9));
            end
            taken_reg      <= 1'b0;
            unl_reg        <= 1'b0;
            retry_reg      <= 1'b0;
            alarm_reg      <= 1'b0;
            chg_reg        <= 1'b0;
            tmo_reg        <= 1'b0;
            cmp_idx_reg    <= '0;
            mismatch_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == kpl_pkg::REG_IDLE_LIMIT) begin
                    idle_limit_reg <= cfg_data;
                end else if (cfg_index == kpl_pkg::REG_MAX_ATTEMPTS) begin
                    max_att_reg <= cfg_data[3:0];
                end
            end
            menu_reg      <= menu_next;
            mode_reg      <= mode_next;
            entry_pos_reg <= entry_pos_next;
            chg_pos_reg   <= chg_pos_next;
            fail_reg      <= fail_next;
            idle_reg      <= idle_next;
            entered_reg   <= entered_next;
            stored_reg    <= stored_next;
            taken_reg     <= taken_next;
            unl_reg       <= unl_next;
            retry_reg     <= retry_next;
            alarm_reg     <= alarm_next;
            chg_reg       <= chg_next;
            tmo_reg       <= tmo_next;

            if (ctrl_cmd.exec) begin
                cmp_idx_reg  <= '0;
                mismatch_reg <= 1'b0;
            end else if (ctrl_cmd.cmp_step) begin
                cmp_idx_reg  <= cmp_idx_reg + IDX_W'(1);
                mismatch_reg <= mismatch_reg
                                | (entered_reg[cmp_idx_reg] != stored_reg[cmp_idx_reg]);
            end

            if (ctrl_cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.latch_item) begin
            item_cmd_reg <= s_cmd;
            item_key_reg <= s_key_code;
        end
        if (ctrl_cmd.load_out) begin
            m_view         <= menu_reg;
            m_mode         <= mode_reg;
            m_digit_taken  <= taken_reg;
            m_unlocked     <= unl_reg;
            m_wrong_retry  <= retry_reg;
            m_alarm        <= alarm_reg;
            m_pass_changed <= chg_reg;
            m_timed_out    <= tmo_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign dp_status.need_cmp = need_cmp;
    assign dp_status.cmp_last = (cmp_idx_reg == IDX_LAST);
    assign dp_status.out_free = !m_valid_reg || m_ready;

endmodule

@@ sv/kpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Keypad password lock controller
// Sequences one item: latch, execute, optional serial compare and resolve, result load.
// ----------------------------------------------------------------------------
module kpl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  kpl_pkg::dp_status_t  dp_status,
    output kpl_pkg::ctrl_cmd_t   ctrl_cmd
);

    kpl_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kpl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = kpl_pkg::ST_EXEC;
                end
            end
            kpl_pkg::ST_EXEC: begin
                state_next = dp_status.need_cmp ? kpl_pkg::ST_CMP : kpl_pkg::ST_DONE;
            end
            kpl_pkg::ST_CMP: begin
                if (dp_status.cmp_last) begin
                    state_next = kpl_pkg::ST_RESOLVE;
                end
            end
            kpl_pkg::ST_RESOLVE: begin
                state_next = kpl_pkg::ST_DONE;
            end
            kpl_pkg::ST_DONE: begin
                if (dp_status.out_free) begin
                    state_next = kpl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kpl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        ctrl_cmd = '0;
        case (state_reg)
            kpl_pkg::ST_IDLE: begin
                s_ready             = 1'b1;
                ctrl_cmd.latch_item = s_valid;
            end
            kpl_pkg::ST_EXEC: begin
                ctrl_cmd.exec = 1'b1;
            end
            kpl_pkg::ST_CMP: begin
                ctrl_cmd.cmp_step = 1'b1;
            end
            kpl_pkg::ST_RESOLVE: begin
                ctrl_cmd.resolve = 1'b1;
            end
            kpl_pkg::ST_DONE: begin
                ctrl_cmd.load_out = dp_status.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kpl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/keypad_password_lock.sv @@
// ----------------------------------------------------------------------------
// Keypad password lock
// Takes key presses, menu-button events and timer ticks, one per item, and
// returns one result item for each: the view, the mode and the event pulses.
// An accepted item is latched and executed, then its result is loaded into
// the output register. A key that completes a check entry also goes through
// the compare and resolve steps, as the entered digits are compared with the
// stored password one pair per cycle. A new item is accepted as soon as the
// previous result sits in the output register; if that result is still not
// taken when the next one is ready, the block waits for the output side.
// Configuration writes are taken in any cycle. There is no clearing pass.
// ----------------------------------------------------------------------------
`include "keypad_password_lock_macros.svh"

module keypad_password_lock #(
    parameter int PASS_LEN = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  logic [7:0]                      s_key_code,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_view,
    output logic [1:0]                      m_mode,
    output logic                            m_digit_taken,
    output logic                            m_unlocked,
    output logic                            m_wrong_retry,
    output logic                            m_alarm,
    output logic                            m_pass_changed,
    output logic                            m_timed_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kpl_pkg::ctrl_cmd_t  ctrl_cmd;
    kpl_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    kpl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    kpl_datapath #(
        .PASS_LEN (PASS_LEN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_cmd       (ctrl_cmd),
        .dp_status      (dp_status),
        .s_cmd          (s_cmd),
        .s_key_code     (s_key_code),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_view         (m_view),
        .m_mode         (m_mode),
        .m_digit_taken  (m_digit_taken),
        .m_unlocked     (m_unlocked),
        .m_wrong_retry  (m_wrong_retry),
        .m_alarm        (m_alarm),
        .m_pass_changed (m_pass_changed),
        .m_timed_out    (m_timed_out)
    );

    // An accepted item keeps the input side closed in the cycle after it.
    `KPL_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")

    // Compare outcomes only come with a stored digit in check mode.
    `KPL_ASSERT_SAME(a_verdict_digit, m_valid && (m_unlocked || m_wrong_retry || m_alarm), m_digit_taken && (m_mode == kpl_pkg::MODE_CHECK), "verdict without check digit")

    // At most one event pulse per result.
    `KPL_ASSERT_SAME(a_one_pulse, m_valid, $onehot0({m_unlocked, m_wrong_retry, m_alarm, m_pass_changed, m_timed_out}), "several pulses in one result")

    // A timeout always lands in the idle view.
    `KPL_ASSERT_SAME(a_timeout_idle, m_valid && m_timed_out, !m_view && !m_digit_taken, "timeout outside idle view")

endmodule
